// ----- rtl/core/taqe_pkg.sv -----
package taqe_pkg;

    localparam int NODES      = 128;
    localparam int LOG_LEVELS = 7;
    localparam int NODE_W     = $clog2(NODES);
    localparam int LVL_W      = $clog2(LOG_LEVELS);
    localparam int JT_DEPTH   = LOG_LEVELS * NODES;
    localparam int JT_AW      = LVL_W + NODE_W;
    localparam int DEPTH_W    = 7;
    localparam int STEPS_W    = 7;
    localparam int MODE_W     = 3;
    localparam int KIND_W     = 2;
    localparam int DIST_W     = 8;

    localparam logic [MODE_W-1:0] MODE_LOAD  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_BUILD = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LCA   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DIST  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_WALK  = 3'd4;

    localparam logic [KIND_W-1:0] KIND_ACK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NODE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DIST = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [NODE_W-1:0]  node_a;
        logic [NODE_W-1:0]  node_b;
        logic [NODE_W-1:0]  parent_node;
        logic [DEPTH_W-1:0] node_depth;
        logic [STEPS_W-1:0] steps_up;
    } t_request;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [NODE_W-1:0] node;
        logic [DIST_W-1:0] distance;
    } t_result;

endpackage

// ----- rtl/core/taqe_req_if.sv -----
interface taqe_req_if;
    import taqe_pkg::*;

    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [NODE_W-1:0]  node_a;
    logic [NODE_W-1:0]  node_b;
    logic [NODE_W-1:0]  parent_node;
    logic [DEPTH_W-1:0] node_depth;
    logic [STEPS_W-1:0] steps_up;

    modport source (
        output valid, mode, node_a, node_b, parent_node, node_depth, steps_up,
        input  ready
    );
    modport sink (
        input  valid, mode, node_a, node_b, parent_node, node_depth, steps_up,
        output ready
    );
endinterface

// ----- rtl/core/taqe_rsp_if.sv -----
interface taqe_rsp_if;
    import taqe_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] answer_kind;
    logic [NODE_W-1:0] answer_node;
    logic [DIST_W-1:0] distance;

    modport source (
        output valid, answer_kind, answer_node, distance,
        input  ready
    );
    modport sink (
        input  valid, answer_kind, answer_node, distance,
        output ready
    );
endinterface

// ----- rtl/core/tree_ancestor_query_engine.sv -----
// Binary-lifting ancestor engine for a rooted tree of nodes 1 to 127 (node 0 means
// "above the root"). Load transactions write a node's parent and depth, a build
// transaction fills jump levels 1 to 6 for nodes 1 to node_count, and query
// transactions return the lowest common ancestor, the edge distance, or the node a
// given number of steps up. One transaction is worked on at a time. Every jump-table
// access is a read loop on the table RAM (address, then registered data), one level per
// loop. The result sits in an output register, so a new transaction is taken while the
// previous result waits. After reset the block clears both RAMs and holds ready low
// meanwhile; node_count may be written at any idle time.
module tree_ancestor_query_engine (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [taqe_pkg::NODE_W-1:0] i_cfg_wdata,
    taqe_req_if.sink                    i_req,
    taqe_rsp_if.source                  o_rsp
);
    import taqe_pkg::*;

    logic [NODE_W-1:0] r_node_count;
    logic              r_out_valid;
    t_result           r_out;

    t_request          req;
    t_result           res;
    logic              res_valid;
    logic              res_ready;
    logic              req_ready;

    assign req.mode        = i_req.mode;
    assign req.node_a      = i_req.node_a;
    assign req.node_b      = i_req.node_b;
    assign req.parent_node = i_req.parent_node;
    assign req.node_depth  = i_req.node_depth;
    assign req.steps_up    = i_req.steps_up;
    assign i_req.ready     = req_ready;

    assign res_ready = !r_out_valid || o_rsp.ready;

    taqe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_node_count(r_node_count),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .i_req       (req),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_W'(1);
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_node_count <= i_cfg_wdata;
            end
            if (res_valid && res_ready) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.answer_kind = r_out.kind;
    assign o_rsp.answer_node = r_out.node;
    assign o_rsp.distance    = r_out.distance;
endmodule

// ----- rtl/core/taqe_ram.sv -----
module taqe_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 7,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);
    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;
endmodule

// ----- rtl/core/taqe_ctrl.sv -----
module taqe_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [taqe_pkg::NODE_W-1:0] i_node_count,
    input  logic                        i_req_valid,
    output logic                        o_req_ready,
    input  taqe_pkg::t_request          i_req,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output taqe_pkg::t_result           o_res
);
    import taqe_pkg::*;

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_BUILD_A  = 4'd2;
    localparam logic [3:0] S_BUILD_B  = 4'd3;
    localparam logic [3:0] S_BUILD_C  = 4'd4;
    localparam logic [3:0] S_DEPTH    = 4'd5;
    localparam logic [3:0] S_CLIMB_RD = 4'd6;
    localparam logic [3:0] S_CLIMB_UP = 4'd7;
    localparam logic [3:0] S_LIFT_RD  = 4'd8;
    localparam logic [3:0] S_LIFT_UP  = 4'd9;
    localparam logic [3:0] S_PAR_RD   = 4'd10;
    localparam logic [3:0] S_PAR_UP   = 4'd11;
    localparam logic [3:0] S_DC_RD    = 4'd12;
    localparam logic [3:0] S_DC_UP    = 4'd13;
    localparam logic [3:0] S_OUT      = 4'd14;

    localparam logic [LVL_W-1:0] LVL_TOP  = LVL_W'(LOG_LEVELS - 1);
    localparam logic [JT_AW-1:0] CLR_LAST = JT_AW'(JT_DEPTH - 1);

    logic [3:0]         r_state, n_state;
    logic [JT_AW-1:0]   r_cnt, n_cnt;
    logic [LVL_W-1:0]   r_lvl, n_lvl;
    logic [NODE_W-1:0]  r_j, n_j;
    logic [NODE_W-1:0]  r_u, n_u;
    logic [NODE_W-1:0]  r_v, n_v;
    logic [MODE_W-1:0]  r_mode, n_mode;
    logic [STEPS_W-1:0] r_steps, n_steps;
    logic [DEPTH_W-1:0] r_da, n_da;
    logic [DEPTH_W-1:0] r_db, n_db;
    t_result            r_res, n_res;

    logic               jt_we;
    logic [JT_AW-1:0]   jt_waddr;
    logic [NODE_W-1:0]  jt_wdata;
    logic [JT_AW-1:0]   jt_raddr_a;
    logic [JT_AW-1:0]   jt_raddr_b;
    logic [NODE_W-1:0]  jt_rd_a;
    logic [NODE_W-1:0]  jt_rd_b;

    logic               dp_we;
    logic [NODE_W-1:0]  dp_waddr;
    logic [DEPTH_W-1:0] dp_wdata;
    logic [NODE_W-1:0]  dp_raddr_a;
    logic [NODE_W-1:0]  dp_raddr_b;
    logic [DEPTH_W-1:0] dp_rd_a;
    logic [DEPTH_W-1:0] dp_rd_b;

    logic [NODE_W-1:0]  climb_u;
    logic               lift_take;
    logic [9:0]         d_sum;
    logic [DIST_W-1:0]  d_clamp;

    taqe_ram #(.DEPTH(JT_DEPTH), .WIDTH(NODE_W)) u_jump_ram (
        .i_clk    (i_clk),
        .i_we     (jt_we),
        .i_waddr  (jt_waddr),
        .i_wdata  (jt_wdata),
        .i_raddr_a(jt_raddr_a),
        .i_raddr_b(jt_raddr_b),
        .o_rdata_a(jt_rd_a),
        .o_rdata_b(jt_rd_b)
    );

    taqe_ram #(.DEPTH(NODES), .WIDTH(DEPTH_W)) u_depth_ram (
        .i_clk    (i_clk),
        .i_we     (dp_we),
        .i_waddr  (dp_waddr),
        .i_wdata  (dp_wdata),
        .i_raddr_a(dp_raddr_a),
        .i_raddr_b(dp_raddr_b),
        .o_rdata_a(dp_rd_a),
        .o_rdata_b(dp_rd_b)
    );

    assign climb_u   = r_steps[r_lvl] ? jt_rd_a : r_u;
    assign lift_take = (jt_rd_a != '0) && (jt_rd_a != jt_rd_b);
    // depth(a) + depth(b) - 2 * depth(c), two's complement
    assign d_sum     = {3'b000, r_da} + {3'b000, r_db} - {2'b00, dp_rd_a, 1'b0};
    assign d_clamp   = d_sum[9] ? '0 : (d_sum[8] ? '1 : d_sum[DIST_W-1:0]);

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_OUT);
    assign o_res       = r_res;

    // read addresses: lvl-1 during build, level 0 for the parent read, lvl elsewhere
    always_comb begin
        dp_raddr_a = (r_state == S_IDLE) ? i_req.node_a : r_u;
        dp_raddr_b = i_req.node_b;
        unique case (r_state)
            S_BUILD_A: jt_raddr_a = {r_lvl - LVL_W'(1), r_j};
            S_BUILD_B: jt_raddr_a = {r_lvl - LVL_W'(1), jt_rd_a};
            S_PAR_RD:  jt_raddr_a = {LVL_W'(0), r_u};
            default:   jt_raddr_a = {r_lvl, r_u};
        endcase
        jt_raddr_b = {r_lvl, r_v};
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_lvl   = r_lvl;
        n_j     = r_j;
        n_u     = r_u;
        n_v     = r_v;
        n_mode  = r_mode;
        n_steps = r_steps;
        n_da    = r_da;
        n_db    = r_db;
        n_res   = r_res;

        jt_we    = 1'b0;
        jt_waddr = {LVL_W'(0), i_req.node_a};
        jt_wdata = i_req.parent_node;
        dp_we    = 1'b0;
        dp_waddr = i_req.node_a;
        dp_wdata = i_req.node_depth;

        unique case (r_state)
            S_CLEAR: begin
                jt_we    = 1'b1;
                jt_waddr = r_cnt;
                jt_wdata = '0;
                dp_we    = (r_cnt[JT_AW-1:NODE_W] == '0);
                dp_waddr = r_cnt[NODE_W-1:0];
                dp_wdata = '0;
                n_cnt    = r_cnt + JT_AW'(1);
                if (r_cnt == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    n_mode  = i_req.mode;
                    n_u     = i_req.node_a;
                    n_v     = i_req.node_b;
                    n_steps = i_req.steps_up;
                    n_res   = '0;
                    n_state = S_OUT;
                    unique case (i_req.mode)
                        MODE_LOAD: begin
                            // node 0 is the above-root mark and stays zero
                            jt_we = (i_req.node_a != '0);
                            dp_we = (i_req.node_a != '0);
                        end
                        MODE_BUILD: begin
                            n_lvl = LVL_W'(1);
                            n_j   = NODE_W'(1);
                            if (i_node_count != '0) begin
                                n_state = S_BUILD_A;
                            end
                        end
                        MODE_LCA, MODE_DIST: begin
                            n_state = S_DEPTH;
                        end
                        MODE_WALK: begin
                            n_lvl   = LVL_TOP;
                            n_state = S_CLIMB_RD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_BUILD_A: begin
                n_state = S_BUILD_B;
            end
            S_BUILD_B: begin
                n_state = S_BUILD_C;
            end
            S_BUILD_C: begin
                jt_we    = 1'b1;
                jt_waddr = {r_lvl, r_j};
                jt_wdata = jt_rd_a;
                n_state  = S_BUILD_A;
                if (r_j == i_node_count) begin
                    n_j = NODE_W'(1);
                    if (r_lvl == LVL_TOP) begin
                        n_state = S_OUT;
                    end else begin
                        n_lvl = r_lvl + LVL_W'(1);
                    end
                end else begin
                    n_j = r_j + NODE_W'(1);
                end
            end
            S_DEPTH: begin
                n_da  = dp_rd_a;
                n_db  = dp_rd_b;
                n_lvl = LVL_TOP;
                if (dp_rd_a < dp_rd_b) begin
                    n_u     = r_v;
                    n_v     = r_u;
                    n_steps = dp_rd_b - dp_rd_a;
                end else begin
                    n_steps = dp_rd_a - dp_rd_b;
                end
                n_state = S_CLIMB_RD;
            end
            S_CLIMB_RD: begin
                n_state = S_CLIMB_UP;
            end
            S_CLIMB_UP: begin
                n_u = climb_u;
                if (r_lvl != '0) begin
                    n_lvl   = r_lvl - LVL_W'(1);
                    n_state = S_CLIMB_RD;
                end else if (r_mode == MODE_WALK) begin
                    n_res.kind = KIND_NODE;
                    n_res.node = climb_u;
                    n_state    = S_OUT;
                end else if (climb_u == r_v) begin
                    // deeper node lands on the other one: it is the ancestor
                    if (r_mode == MODE_LCA) begin
                        n_res.kind = KIND_NODE;
                        n_res.node = climb_u;
                        n_state    = S_OUT;
                    end else begin
                        n_state = S_DC_RD;
                    end
                end else begin
                    n_lvl   = LVL_TOP;
                    n_state = S_LIFT_RD;
                end
            end
            S_LIFT_RD: begin
                n_state = S_LIFT_UP;
            end
            S_LIFT_UP: begin
                if (lift_take) begin
                    n_u = jt_rd_a;
                    n_v = jt_rd_b;
                end
                if (r_lvl != '0) begin
                    n_lvl   = r_lvl - LVL_W'(1);
                    n_state = S_LIFT_RD;
                end else begin
                    n_state = S_PAR_RD;
                end
            end
            S_PAR_RD: begin
                n_state = S_PAR_UP;
            end
            S_PAR_UP: begin
                n_u = jt_rd_a;
                if (r_mode == MODE_LCA) begin
                    n_res.kind = KIND_NODE;
                    n_res.node = jt_rd_a;
                    n_state    = S_OUT;
                end else begin
                    n_state = S_DC_RD;
                end
            end
            S_DC_RD: begin
                n_state = S_DC_UP;
            end
            S_DC_UP: begin
                n_res.kind     = KIND_DIST;
                n_res.distance = d_clamp;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lvl   <= n_lvl;
        r_j     <= n_j;
        r_u     <= n_u;
        r_v     <= n_v;
        r_mode  <= n_mode;
        r_steps <= n_steps;
        r_da    <= n_da;
        r_db    <= n_db;
        r_res   <= n_res;
    end
endmodule

// ----- rtl/core/taqe_checker.sv -----
module taqe_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_req_valid,
    input logic                        i_req_ready,
    input logic                        i_rsp_valid,
    input logic                        i_rsp_ready,
    input logic [taqe_pkg::KIND_W-1:0] i_rsp_kind,
    input logic [taqe_pkg::NODE_W-1:0] i_rsp_node,
    input logic [taqe_pkg::DIST_W-1:0] i_rsp_dist
);
    import taqe_pkg::*;

    // stalled result holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_kind)
            && $stable(i_rsp_node) && $stable(i_rsp_dist))
        else $error("result changed while stalled");

    // RAM clearing pass keeps the input closed right after reset
    a_clear_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_req_ready)
        else $error("ready during clearing pass");

    // one transaction in work at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("ready right after an accept");

    a_ack_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_kind == KIND_ACK |-> i_rsp_node == '0 && i_rsp_dist == '0)
        else $error("acknowledge with nonzero fields");

    a_kind_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_kind == KIND_NODE && i_rsp_dist == '0)
            || (i_rsp_kind == KIND_DIST && i_rsp_node == '0)
            || i_rsp_kind == KIND_ACK)
        else $error("result fields do not match answer kind");
endmodule

bind tree_ancestor_query_engine taqe_checker u_taqe_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_req_valid(i_req.valid),
    .i_req_ready(i_req.ready),
    .i_rsp_valid(o_rsp.valid),
    .i_rsp_ready(o_rsp.ready),
    .i_rsp_kind (o_rsp.answer_kind),
    .i_rsp_node (o_rsp.answer_node),
    .i_rsp_dist (o_rsp.distance)
);
